[rtl/core/dsdb_pkg.sv]
`default_nettype none

package dsdb_pkg;

  // Input word: one victim request or one replacement state update.
  typedef struct packed {
    logic        mode;
    logic [10:0] set_index;
    logic [3:0]  way;
    logic [11:0] pc_low;
    logic        hit;
    logic        rare_near_insert;
  } dsdb_in_t;

  // Output word: one per input word.
  typedef struct packed {
    logic [3:0] victim_way;
    logic       victim_was_dead;
    logic [9:0] selector_value;
  } dsdb_out_t;

  // Per-item control handed from the sequencer to the row update logic.
  typedef struct packed {
    logic mode;
    logic hit;
    logic rare;
    logic srrip_leader;
    logic brrip_leader;
  } dsdb_ctrl_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } dsdb_state_t;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam int SET_IN_W  = 11;
  localparam int WAY_IN_W  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SRRIP_LEADERS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRRIP_LEADERS = 1'b1;

  localparam logic       MODE_VICTIM  = 1'b0;
  localparam logic [1:0] RRPV_NEAR    = 2'd0;
  localparam logic [1:0] RRPV_LONG    = 2'd2;
  localparam logic [1:0] RRPV_DISTANT = 2'd3;
  localparam logic [1:0] CTR_MAX      = 2'd3;
  localparam logic [1:0] CTR_REUSED   = 2'd2;
  localparam logic [1:0] CTR_RESET    = 2'd1;
  localparam logic [CFG_W-1:0] LEADERS_RESET = 12'd16;

endpackage

`default_nettype wire

[rtl/core/dsdb_ram.sv]
`default_nettype none

module dsdb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/dsdb_row_update.sv]
`default_nettype none

module dsdb_row_update
  import dsdb_pkg::*;
#(
  parameter int WAYS          = 16,
  parameter int SIG_BITS      = 6,
  parameter int SELECTOR_BITS = 10,
  localparam int WAY_W        = $clog2(WAYS),
  localparam int SIGC         = 1 << SIG_BITS,
  localparam int ROW_W        = 3 * WAYS + 2 * SIGC
) (
  input  wire dsdb_ctrl_t               ctrl,
  input  wire logic [WAY_W-1:0]         way,
  input  wire logic [SIG_BITS-1:0]      sig,
  input  wire logic [ROW_W-1:0]         row,
  input  wire logic [SELECTOR_BITS-1:0] selector,
  output logic      [ROW_W-1:0]         row_next,
  output logic      [WAY_W-1:0]         victim,
  output logic                          victim_was_dead,
  output logic      [SELECTOR_BITS-1:0] selector_next
);

  localparam logic [SELECTOR_BITS-1:0] SEL_MID = SELECTOR_BITS'(1 << (SELECTOR_BITS - 1));
  localparam logic [SELECTOR_BITS-1:0] SEL_MAX = {SELECTOR_BITS{1'b1}};

  logic [1:0] rrpv     [WAYS];
  logic       dead     [WAYS];
  logic [1:0] ctr_arr  [SIGC];
  logic [1:0] rrpv_new [WAYS];
  logic       dead_new [WAYS];
  logic [1:0] ctr_new  [SIGC];
  logic       dead_any;
  logic [WAY_W-1:0] dead_way;
  logic [WAY_W-1:0] best_way;
  logic       any3, any2, any1;
  logic [1:0] top;
  logic [1:0] lift;
  logic [1:0] ctr;
  logic       bimodal_insert;

  // Split the row into its fields and pack the new fields back.
  for (genvar i = 0; i < WAYS; i++) begin : g_ways
    assign rrpv[i] = row[2*i +: 2];
    assign dead[i] = row[2*WAYS + i];
    assign row_next[2*i +: 2]   = rrpv_new[i];
    assign row_next[2*WAYS + i] = dead_new[i];
  end
  for (genvar j = 0; j < SIGC; j++) begin : g_sigs
    assign ctr_arr[j] = row[3*WAYS + 2*j +: 2];
    assign row_next[3*WAYS + 2*j +: 2] = ctr_new[j];
  end

  assign ctr = ctr_arr[sig];

  // Priority encoders: first dead way, and first way holding the largest RRPV.
  always_comb begin
    dead_any = 1'b0;
    dead_way = '0;
    any3     = 1'b0;
    any2     = 1'b0;
    any1     = 1'b0;
    best_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (dead[i]) begin
        dead_any = 1'b1;
        dead_way = WAY_W'(i);
      end
      any3 = any3 | (rrpv[i] == 2'd3);
      any2 = any2 | (rrpv[i] == 2'd2);
      any1 = any1 | (rrpv[i] == 2'd1);
    end
    top  = any3 ? 2'd3 : (any2 ? 2'd2 : (any1 ? 2'd1 : 2'd0));
    lift = 2'd3 - top;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (rrpv[i] == top) begin
        best_way = WAY_W'(i);
      end
    end
  end

  // Insertion policy for a fill that the reuse counter does not decide.
  always_comb begin
    if (ctrl.srrip_leader) begin
      bimodal_insert = 1'b0;
    end else if (ctrl.brrip_leader) begin
      bimodal_insert = 1'b1;
    end else begin
      bimodal_insert = selector < SEL_MID;
    end
  end

  // New row contents, victim and selector.
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      rrpv_new[i] = rrpv[i];
      dead_new[i] = dead[i];
    end
    for (int j = 0; j < SIGC; j++) begin
      ctr_new[j] = ctr_arr[j];
    end
    selector_next   = selector;
    victim          = '0;
    victim_was_dead = 1'b0;

    if (ctrl.mode == MODE_VICTIM) begin
      if (dead_any) begin
        victim          = dead_way;
        victim_was_dead = 1'b1;
      end else begin
        // Ageing the set in one go: every way rises by the gap to distant.
        victim = best_way;
        for (int i = 0; i < WAYS; i++) begin
          rrpv_new[i] = rrpv[i] + lift;
        end
      end
    end else if (ctrl.hit) begin
      rrpv_new[way] = RRPV_NEAR;
      dead_new[way] = 1'b0;
      if (ctr != CTR_MAX) begin
        ctr_new[sig] = ctr + 2'd1;
      end
      if (ctrl.srrip_leader && selector != SEL_MAX) begin
        selector_next = selector + SELECTOR_BITS'(1);
      end
      if (ctrl.brrip_leader && selector != '0) begin
        selector_next = selector - SELECTOR_BITS'(1);
      end
    end else begin
      if (ctr >= CTR_REUSED) begin
        rrpv_new[way] = RRPV_NEAR;
      end else if (bimodal_insert) begin
        rrpv_new[way] = ctrl.rare ? RRPV_LONG : RRPV_DISTANT;
      end else begin
        rrpv_new[way] = RRPV_LONG;
      end
      dead_new[way] = 1'b1;
      if (ctr != 2'd0) begin
        ctr_new[sig] = ctr - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/drrip_ship_dead_block_replacement.sv]
`default_nettype none

// Channel   Direction  Valid      Stall      Word
// in        input      in_valid   in_stall   in_word  (dsdb_in_t)
// out       output     out_valid  out_stall  out_word (dsdb_out_t)
// cfg       input      cfg_we     -          cfg_index / cfg_data
//
// Each word passes through accept, row read, then modify and write back.
// Each word is a read-modify-write of one whole set row in the row memory.
// After reset a clearing pass initialises every row; no word
// is accepted during it. A result waiting on a stalled output holds the write
// back of the next word, while the input still takes one further word.
module drrip_ship_dead_block_replacement
  import dsdb_pkg::*;
#(
  parameter int SETS          = 2048,
  parameter int WAYS          = 16,
  parameter int SIG_BITS      = 6,
  parameter int SELECTOR_BITS = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire dsdb_in_t             in_word,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output dsdb_out_t                 out_word,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int SET_W     = $clog2(SETS);
  localparam int WAY_W     = $clog2(WAYS);
  localparam int SIGC      = 1 << SIG_BITS;
  localparam int ROW_W     = 3 * WAYS + 2 * SIGC;
  localparam int SET_STEPS = (SETS >= 2048) ? 1 : $clog2((2048 + SETS - 1) / SETS) + 1;
  localparam int WAY_STEPS = (WAYS >= 16) ? 1 : $clog2((16 + WAYS - 1) / WAYS) + 1;
  localparam int CMP_W     = 17;
  localparam logic [SELECTOR_BITS-1:0] SEL_RESET = SELECTOR_BITS'(1 << (SELECTOR_BITS - 1));
  localparam logic [ROW_W-1:0] CLEAR_ROW =
    {{SIGC{CTR_RESET}}, {WAYS{1'b0}}, {WAYS{RRPV_DISTANT}}};

  dsdb_state_t              state, state_next;
  dsdb_in_t                 item;
  logic [SET_W-1:0]         clr_cnt;
  logic [CFG_W-1:0]         srrip_cnt;
  logic [CFG_W-1:0]         brrip_cnt;
  logic [SELECTOR_BITS-1:0] selector;
  logic [SELECTOR_BITS-1:0] selector_next;

  logic                     accept;
  logic                     commit;
  logic                     clr_done;
  logic [SET_IN_W-1:0]      set_rem;
  logic [WAY_IN_W-1:0]      way_rem;
  logic [SET_W-1:0]         set_red;
  logic [WAY_W-1:0]         way_red;
  logic [SIG_BITS-1:0]      sig;
  logic [CMP_W-1:0]         set_ext;
  logic                     srrip_leader;
  logic                     brrip_leader;
  dsdb_ctrl_t               ctrl;
  logic                     ram_we;
  logic [SET_W-1:0]         ram_waddr;
  logic [ROW_W-1:0]         ram_wdata;
  logic [ROW_W-1:0]         row;
  logic [ROW_W-1:0]         row_next;
  logic [WAY_W-1:0]         victim;
  logic                     victim_was_dead;

  assign accept   = in_valid && !in_stall;
  assign clr_done = clr_cnt == SET_W'(SETS - 1);

  // Reduce set and way modulo their counts by a short compare-subtract chain.
  always_comb begin
    set_rem = item.set_index;
    for (int k = SET_STEPS - 1; k >= 0; k--) begin
      if (32'(set_rem) >= 32'(SETS << k)) begin
        set_rem = set_rem - SET_IN_W'(SETS << k);
      end
    end
    way_rem = item.way;
    for (int k = WAY_STEPS - 1; k >= 0; k--) begin
      if (32'(way_rem) >= 32'(WAYS << k)) begin
        way_rem = way_rem - WAY_IN_W'(WAYS << k);
      end
    end
    set_red = SET_W'(set_rem);
    way_red = WAY_W'(way_rem);
  end

  // Signature hash of the program counter.
  assign sig = SIG_BITS'(item.pc_low ^ (item.pc_low >> 6));

  // Leader set classification; an SRRIP leader is never a BRRIP leader.
  assign set_ext      = CMP_W'(set_red);
  assign srrip_leader = set_ext < CMP_W'(srrip_cnt);
  assign brrip_leader = !srrip_leader &&
                        (set_ext < CMP_W'(srrip_cnt) + CMP_W'(brrip_cnt));

  assign ctrl = '{mode: item.mode, hit: item.hit, rare: item.rare_near_insert,
                  srrip_leader: srrip_leader, brrip_leader: brrip_leader};

  dsdb_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (set_red),
    .rdata (row)
  );

  dsdb_row_update #(
    .WAYS          (WAYS),
    .SIG_BITS      (SIG_BITS),
    .SELECTOR_BITS (SELECTOR_BITS)
  ) u_row_update (
    .ctrl            (ctrl),
    .way             (way_red),
    .sig             (sig),
    .row             (row),
    .selector        (selector),
    .row_next        (row_next),
    .victim          (victim),
    .victim_was_dead (victim_was_dead),
    .selector_next   (selector_next)
  );

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall  = 1'b1;
    commit    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = set_red;
    ram_wdata = row_next;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = CLEAR_ROW;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_WRITE: begin
        commit = !out_valid || !out_stall;
        ram_we = commit;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      selector  <= SEL_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + SET_W'(1);
      end
      if (commit) begin
        selector  <= selector_next;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Leader counts, written through the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      srrip_cnt <= LEADERS_RESET;
      brrip_cnt <= LEADERS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SRRIP_LEADERS: srrip_cnt <= cfg_data;
        CFG_BRRIP_LEADERS: brrip_cnt <= cfg_data;
        default: begin
          srrip_cnt <= srrip_cnt;
        end
      endcase
    end
  end

  // Payload registers: the accepted word and the result word.
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_word;
    end
    if (commit) begin
      out_word.victim_way      <= WAY_IN_W'(victim);
      out_word.victim_was_dead <= victim_was_dead;
      out_word.selector_value  <= 10'(selector_next);
    end
  end

`ifndef SYNTHESIS
  a_accept_then_read : assert property (@(posedge clk) disable iff (rst)
    (!rst && accept) |=> (state == ST_READ))
    else $error("accepted word did not start a row read");

  a_commit_sets_valid : assert property (@(posedge clk) disable iff (rst)
    (!rst && commit) |=> out_valid)
    else $error("committed word did not reach the output register");

  a_selector_only_on_commit : assert property (@(posedge clk) disable iff (rst)
    (!rst && !commit) |=> $stable(selector))
    else $error("selector changed without a committed word");

  a_no_result_while_clearing : assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !out_valid)
    else $error("result present during the clearing pass");

  a_ram_write_states : assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLEAR || state == ST_WRITE))
    else $error("row memory written outside clear or write back");
`endif

endmodule

`default_nettype wire
